### sv/wfps_pkg.sv
// Shared types and constants for the wall-follow PID steering block.
// Used by every module of the block; depends on nothing.
package wfps_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_FOLLOW_MODE     = 3'd0;
  localparam logic [2:0] CFG_TARGET_DISTANCE = 3'd1;
  localparam logic [2:0] CFG_BAND_HALF_WIDTH = 3'd2;
  localparam logic [2:0] CFG_FRONT_THRESHOLD = 3'd3;
  localparam logic [2:0] CFG_GAIN_P          = 3'd4;
  localparam logic [2:0] CFG_GAIN_I          = 3'd5;
  localparam logic [2:0] CFG_GAIN_D          = 3'd6;

  // Follow modes (code 3 behaves as stop)
  localparam logic [1:0] MODE_STOP  = 2'd0;
  localparam logic [1:0] MODE_RIGHT = 2'd1;
  localparam logic [1:0] MODE_LEFT  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_STOPPED  = 2'd0;
  localparam logic [1:0] STAT_TRACKING = 2'd1;
  localparam logic [1:0] STAT_SLOWED   = 2'd2;
  localparam logic [1:0] STAT_EVASIVE  = 2'd3;

  // Register reset values
  localparam logic [1:0]         RST_FOLLOW_MODE     = MODE_RIGHT;
  localparam logic [15:0]        RST_TARGET_DISTANCE = 16'd512;
  localparam logic [15:0]        RST_BAND_HALF_WIDTH = 16'd512;
  localparam logic [15:0]        RST_FRONT_THRESHOLD = 16'd768;
  localparam logic signed [15:0] RST_GAIN_P          = 16'sd77;
  localparam logic signed [15:0] RST_GAIN_I          = 16'sd0;
  localparam logic signed [15:0] RST_GAIN_D          = 16'sd768;

  // Q1.14 command constants
  localparam logic [14:0]        SPEED_CRUISE = 15'd8192;
  localparam logic [14:0]        SPEED_SLOW   = 15'd1638;
  localparam logic signed [15:0] TURN_FULL    = 16'sd16384;

  // Q16.16 clamp limits, PID sum width
  localparam logic signed [36:0] SUM_MAX = 37'sd65536;
  localparam logic signed [36:0] SUM_MIN = -37'sd65536;
  // Integral saturation limits in the 35-bit accumulate width
  localparam logic signed [34:0] ACC_MAX = 35'sh0_7FFF_FFFF;
  localparam logic signed [34:0] ACC_MIN = 35'sh7_8000_0000;

  typedef struct packed {
    logic [15:0] front_distance;
    logic [15:0] left_distance;
    logic [15:0] right_distance;
  } wfps_in_t;

  typedef struct packed {
    logic signed [15:0] turn_rate;
    logic [14:0]        forward_speed;
    logic [1:0]         status;
  } wfps_out_t;

  typedef struct packed {
    logic [1:0]         follow_mode;
    logic [15:0]        target_distance;
    logic [15:0]        band_half_width;
    logic [15:0]        front_threshold;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
  } wfps_cfg_t;

  // Classified item handed from the front end to the PID back end
  typedef struct packed {
    logic               active;     // mode on and distance inside the band
    logic               left_side;  // following the left wall
    logic signed [17:0] err;        // target - distance, Q8.8
    logic               slow;       // front obstacle within 1.5 * threshold
    logic               evade;      // front obstacle within threshold
    logic               turn_pos;   // evasive turn direction is positive
  } wfps_cls_t;

endpackage

### sv/wfps_front.sv
// Front end: classifies an incoming range sample into a queue entry.
// Depends on wfps_pkg.
module wfps_front (
  input  wfps_pkg::wfps_cfg_t cfg,
  input  wfps_pkg::wfps_in_t  smp,
  output wfps_pkg::wfps_cls_t cls
);

  logic [15:0]        side_dist;
  logic               mode_on;
  logic               left_side;
  logic [16:0]        band_hi;
  logic signed [17:0] band_lo;
  logic [16:0]        front_x2;
  logic [17:0]        thr_x3;

  always_comb begin
    left_side = (cfg.follow_mode == wfps_pkg::MODE_LEFT);
    mode_on   = (cfg.follow_mode == wfps_pkg::MODE_RIGHT) || left_side;
    side_dist = left_side ? smp.left_distance : smp.right_distance;
    band_hi   = {1'b0, cfg.target_distance} + {1'b0, cfg.band_half_width};
    band_lo   = $signed({2'b00, cfg.target_distance}) - $signed({2'b00, cfg.band_half_width});
    front_x2  = {smp.front_distance, 1'b0};
    thr_x3    = {2'b00, cfg.front_threshold} + {1'b0, cfg.front_threshold, 1'b0};

    cls.active    = mode_on && ({1'b0, side_dist} < band_hi) &&
                    ($signed({2'b00, side_dist}) > band_lo);
    cls.left_side = left_side;
    cls.err       = $signed({2'b00, cfg.target_distance}) - $signed({2'b00, side_dist});
    cls.slow      = (smp.front_distance != 16'd0) && ({1'b0, front_x2} < thr_x3);
    cls.evade     = cls.slow && (smp.front_distance < cfg.front_threshold);
    cls.turn_pos  = smp.left_distance < smp.right_distance;
  end

endmodule

### sv/wfps_queue.sv
// Short FIFO of classified items between front end and PID back end.
// Depends on wfps_pkg.
module wfps_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wfps_pkg::wfps_cls_t wr_data,
  input  logic                pop,
  output wfps_pkg::wfps_cls_t rd_data,
  output logic                full,
  output logic                not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  wfps_pkg::wfps_cls_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### sv/wfps_back.sv
// PID back end: products and integral/last-error update, then sum, clamp and
// command selection into the output register. Depends on wfps_pkg.
module wfps_back (
  input  logic                clk,
  input  logic                rst_n,
  input  wfps_pkg::wfps_cfg_t cfg,
  input  logic                q_valid,
  input  wfps_pkg::wfps_cls_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output wfps_pkg::wfps_out_t out_data
);

  // PID state
  logic signed [17:0] last_err_r;
  logic signed [31:0] integ_r, integ_nxt;

  // stage 1 registers
  logic               s1_valid_r;
  logic               s1_active_r;
  logic               s1_left_r;
  logic               s1_slow_r;
  logic               s1_evade_r;
  logic               s1_turn_pos_r;
  logic signed [33:0] s1_p_r;
  logic signed [31:0] s1_acc_r;
  logic signed [34:0] s1_d_r;

  // output register
  logic                out_valid_r;
  wfps_pkg::wfps_out_t out_data_r, out_data_nxt;

  logic               s1_adv;
  logic signed [33:0] p_prod;
  logic signed [33:0] i_prod;
  logic signed [34:0] acc_sum;
  logic signed [18:0] err_diff;
  logic signed [34:0] d_prod;
  logic signed [36:0] pid_sum;
  logic signed [17:0] pid_clamp;
  logic signed [17:0] turn_q14;
  logic signed [15:0] turn_pid;

  assign s1_adv    = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && (!s1_valid_r || s1_adv);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // stage 1: products and saturated integral
  always_comb begin
    p_prod   = cfg.gain_p * q_data.err;
    i_prod   = cfg.gain_i * q_data.err;
    acc_sum  = 35'(integ_r) + 35'(i_prod);
    err_diff = 19'(q_data.err) - 19'(last_err_r);
    d_prod   = cfg.gain_d * err_diff;
    if (acc_sum > wfps_pkg::ACC_MAX) begin
      integ_nxt = 32'sh7FFF_FFFF;
    end else if (acc_sum < wfps_pkg::ACC_MIN) begin
      integ_nxt = 32'sh8000_0000;
    end else begin
      integ_nxt = acc_sum[31:0];
    end
  end

  // stage 2: sum, clamp, Q16.16 -> Q1.14 with round half up, command select
  always_comb begin
    pid_sum = 37'(s1_p_r) + 37'(s1_acc_r) + 37'(s1_d_r);
    if (pid_sum > wfps_pkg::SUM_MAX) begin
      pid_clamp = 18'sd65536;
    end else if (pid_sum < wfps_pkg::SUM_MIN) begin
      pid_clamp = -18'sd65536;
    end else begin
      pid_clamp = pid_sum[17:0];
    end
    turn_q14 = (pid_clamp + 18'sd2) >>> 2;
    turn_pid = s1_left_r ? -turn_q14[15:0] : turn_q14[15:0];

    out_data_nxt.turn_rate     = '0;
    out_data_nxt.forward_speed = '0;
    out_data_nxt.status        = wfps_pkg::STAT_STOPPED;
    if (s1_active_r) begin
      if (s1_evade_r) begin
        out_data_nxt.turn_rate     = s1_turn_pos_r ? wfps_pkg::TURN_FULL
                                                   : -wfps_pkg::TURN_FULL;
        out_data_nxt.forward_speed = wfps_pkg::SPEED_SLOW;
        out_data_nxt.status        = wfps_pkg::STAT_EVASIVE;
      end else if (s1_slow_r) begin
        out_data_nxt.turn_rate     = turn_pid;
        out_data_nxt.forward_speed = wfps_pkg::SPEED_SLOW;
        out_data_nxt.status        = wfps_pkg::STAT_SLOWED;
      end else begin
        out_data_nxt.turn_rate     = turn_pid;
        out_data_nxt.forward_speed = wfps_pkg::SPEED_CRUISE;
        out_data_nxt.status        = wfps_pkg::STAT_TRACKING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r  <= '0;
      integ_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop && q_data.active) begin
        last_err_r <= q_data.err;
        integ_r    <= integ_nxt;
      end
      if (q_pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_active_r   <= q_data.active;
      s1_left_r     <= q_data.left_side;
      s1_slow_r     <= q_data.slow;
      s1_evade_r    <= q_data.evade;
      s1_turn_pos_r <= q_data.turn_pos;
      s1_p_r        <= p_prod;
      s1_acc_r      <= integ_nxt;
      s1_d_r        <= d_prod;
    end
    if (s1_adv && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

### sv/wall_follow_pid_steer_top.sv
// Top level of the wall-follow PID steering block: config registers, front end,
// item queue and PID back end. Depends on wfps_pkg, wfps_front, wfps_queue, wfps_back.

// Wall-following steering controller. Each transfer on the in_ channel carries
// front, left and right range readings (unsigned Q8.8 metres) and produces
// exactly one transfer on the out_ channel: turn rate and forward speed in
// Q1.14 plus a status code (stopped, tracking, slowed, evasive turn). The block
// sustains one item per clock cycle while out_stall is low. With an empty
// queue an item is classified and enqueued, then taken by the PID product
// stage (which also updates the integral and last-error state in the same
// cycle, and that state loop sets the rate), then by the sum/clamp stage into
// the output register. A QUEUE_DEPTH-entry queue sits between the
// classifier and the PID stages; in_stall rises only when it is full, so the
// input side keeps moving while a result waits on out_stall. Items outside
// the tracking band, or in stop mode, still pass through and give an all-zero
// result without touching the PID state. Configuration registers are written
// through cfg_we/cfg_addr/cfg_wdata and must only change while the block is
// idle; unknown indexes are ignored. No post-reset initialization is needed.
module wall_follow_pid_steer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  wfps_pkg::wfps_in_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output wfps_pkg::wfps_out_t out_data,
  // configuration write port
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [15:0]         cfg_wdata
);

  wfps_pkg::wfps_cfg_t cfg_r;
  wfps_pkg::wfps_cls_t cls;
  wfps_pkg::wfps_cls_t q_head;
  logic                q_full;
  logic                q_not_empty;
  logic                q_pop;
  logic                in_xfer;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.follow_mode     <= wfps_pkg::RST_FOLLOW_MODE;
      cfg_r.target_distance <= wfps_pkg::RST_TARGET_DISTANCE;
      cfg_r.band_half_width <= wfps_pkg::RST_BAND_HALF_WIDTH;
      cfg_r.front_threshold <= wfps_pkg::RST_FRONT_THRESHOLD;
      cfg_r.gain_p          <= wfps_pkg::RST_GAIN_P;
      cfg_r.gain_i          <= wfps_pkg::RST_GAIN_I;
      cfg_r.gain_d          <= wfps_pkg::RST_GAIN_D;
    end else if (cfg_we) begin
      case (cfg_addr)
        wfps_pkg::CFG_FOLLOW_MODE:     cfg_r.follow_mode     <= cfg_wdata[1:0];
        wfps_pkg::CFG_TARGET_DISTANCE: cfg_r.target_distance <= cfg_wdata;
        wfps_pkg::CFG_BAND_HALF_WIDTH: cfg_r.band_half_width <= cfg_wdata;
        wfps_pkg::CFG_FRONT_THRESHOLD: cfg_r.front_threshold <= cfg_wdata;
        wfps_pkg::CFG_GAIN_P:          cfg_r.gain_p          <= $signed(cfg_wdata);
        wfps_pkg::CFG_GAIN_I:          cfg_r.gain_i          <= $signed(cfg_wdata);
        wfps_pkg::CFG_GAIN_D:          cfg_r.gain_d          <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  assign in_stall = q_full;
  assign in_xfer  = in_valid && !q_full;

  // classify against band and front thresholds
  wfps_front u_front (
    .cfg (cfg_r),
    .smp (in_data),
    .cls (cls)
  );

  // decouples classification from the PID stages
  wfps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .wr_data   (cls),
    .pop       (q_pop),
    .rd_data   (q_head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // PID law, state update and output register
  wfps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_not_empty),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sv/wfps_checker.sv
// Port-level checks for the wall-follow PID steering block, bound to the top.
// Depends on wfps_pkg and wall_follow_pid_steer_top.
module wfps_port_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input wfps_pkg::wfps_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

  // stopped results carry no motion
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == wfps_pkg::STAT_STOPPED) |->
      (out_data.turn_rate == 16'sd0 && out_data.forward_speed == 15'd0))
    else $error("stopped result with nonzero command");

  // evasive turn is full scale at slow speed
  a_evasive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == wfps_pkg::STAT_EVASIVE) |->
      ((out_data.turn_rate == wfps_pkg::TURN_FULL ||
        out_data.turn_rate == -wfps_pkg::TURN_FULL) &&
       out_data.forward_speed == wfps_pkg::SPEED_SLOW))
    else $error("bad evasive command");

  // speed follows status, turn stays within +/-1.0
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_data.status == wfps_pkg::STAT_TRACKING) ==
         (out_data.forward_speed == wfps_pkg::SPEED_CRUISE)) &&
      out_data.turn_rate <= wfps_pkg::TURN_FULL &&
      out_data.turn_rate >= -wfps_pkg::TURN_FULL)
    else $error("speed or turn out of range");

endmodule

bind wall_follow_pid_steer_top wfps_port_checker u_wfps_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### sim/wfps_checker.sv
// Result checker for the wall-follow PID steering block: tracks its registers,
// predicts each steering command and compares it with the result channel.
// Depends on wfps_pkg.
`timescale 1ns / 100ps

module wfps_checker
  import wfps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  wfps_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  wfps_out_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          outstanding
);

  localparam longint ONE_Q16 = 65536;

  // register copy
  logic [1:0]         mode_q;
  logic [15:0]        target_q;
  logic [15:0]        band_q;
  logic [15:0]        thresh_q;
  logic signed [15:0] kp_q;
  logic signed [15:0] ki_q;
  logic signed [15:0] kd_q;

  // controller state
  logic signed [17:0] prev_err_q;
  logic signed [31:0] integ_q;

  wfps_out_t pending_cmds[$];

  // Expected command for one reading; advances the PID state when inside the band.
  function automatic wfps_out_t steer_command(input wfps_in_t rd);
    wfps_out_t cmd;
    longint    side, tgt, band, thr, front, err, p_term, acc, d_term, sum, turn;
    cmd   = '0;
    tgt   = target_q;
    band  = band_q;
    thr   = thresh_q;
    front = rd.front_distance;
    if (mode_q == MODE_RIGHT || mode_q == MODE_LEFT) begin
      if (mode_q == MODE_RIGHT) side = rd.right_distance;
      else side = rd.left_distance;
      if (side < tgt + band && side > tgt - band) begin
        err    = tgt - side;
        p_term = longint'(kp_q) * err;
        acc    = longint'(integ_q) + longint'(ki_q) * err;
        if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
        if (acc < -64'sh8000_0000) acc = -64'sh8000_0000;
        integ_q = acc[31:0];
        d_term  = longint'(kd_q) * (err - longint'(prev_err_q));
        sum = p_term + acc + d_term;
        if (sum > ONE_Q16) sum = ONE_Q16;
        if (sum < -ONE_Q16) sum = -ONE_Q16;
        // Q16.16 -> Q1.14, round half up
        turn = ((sum + ONE_Q16 + 2) >>> 2) - 16384;
        if (mode_q == MODE_LEFT) turn = -turn;
        cmd.turn_rate     = turn[15:0];
        cmd.forward_speed = SPEED_CRUISE;
        cmd.status        = STAT_TRACKING;
        prev_err_q        = err[17:0];
        if (front > 0 && 2 * front < 3 * thr) begin
          if (front < thr) begin
            cmd.turn_rate = (rd.left_distance < rd.right_distance) ? TURN_FULL : -TURN_FULL;
            cmd.status    = STAT_EVASIVE;
          end else begin
            cmd.status = STAT_SLOWED;
          end
          cmd.forward_speed = SPEED_SLOW;
        end
      end
    end
    return cmd;
  endfunction

  always @(posedge clk) begin : monitor
    wfps_out_t want;
    logic      bad;
    if (!rst_n) begin
      mode_q     = RST_FOLLOW_MODE;
      target_q   = RST_TARGET_DISTANCE;
      band_q     = RST_BAND_HALF_WIDTH;
      thresh_q   = RST_FRONT_THRESHOLD;
      kp_q       = RST_GAIN_P;
      ki_q       = RST_GAIN_I;
      kd_q       = RST_GAIN_D;
      prev_err_q = '0;
      integ_q    = '0;
      pending_cmds.delete();
      fail_count  = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FOLLOW_MODE:     mode_q = cfg_wdata[1:0];
          CFG_TARGET_DISTANCE: target_q = cfg_wdata;
          CFG_BAND_HALF_WIDTH: band_q = cfg_wdata;
          CFG_FRONT_THRESHOLD: thresh_q = cfg_wdata;
          CFG_GAIN_P:          kp_q = cfg_wdata;
          CFG_GAIN_I:          ki_q = cfg_wdata;
          CFG_GAIN_D:          kd_q = cfg_wdata;
          default: ;
        endcase
      end
      // retire first: a result never belongs to a reading taken in the same cycle
      if (out_valid && !out_stall) begin
        if (pending_cmds.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transfer %h", $time, out_data);
        end else begin
          want = pending_cmds.pop_front();
          bad  = 1'b0;
          if (out_data.turn_rate !== want.turn_rate) begin
            bad = 1'b1;
            $display("%0t: turn_rate expected %0d got %0d",
                     $time, want.turn_rate, out_data.turn_rate);
          end
          if (out_data.forward_speed !== want.forward_speed) begin
            bad = 1'b1;
            $display("%0t: forward_speed expected %0d got %0d",
                     $time, want.forward_speed, out_data.forward_speed);
          end
          if (out_data.status !== want.status) begin
            bad = 1'b1;
            $display("%0t: status expected %0d got %0d",
                     $time, want.status, out_data.status);
          end
          if (bad) fail_count++;
        end
      end
      if (in_valid && !in_stall) pending_cmds.push_back(steer_command(in_data));
      outstanding <= pending_cmds.size();
    end
  end

endmodule

### sim/wall_follow_pid_steer_top_tb.sv
// Testbench top for the wall-follow PID steering block: clock, reset, reading
// stimulus, register loads, result-side stalling and the verdict.
// Depends on wfps_pkg, wall_follow_pid_steer_top and wfps_checker.
`timescale 1ns / 100ps

module wall_follow_pid_steer_top_tb;
  import wfps_pkg::*;

  // Codes not named in the package: unused mode value and an index past the list
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] CFG_UNUSED  = 3'd7;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 92;
  localparam int HOLD_CYCLES  = 60;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  wfps_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  wfps_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  int fail_count;
  int outstanding;

  // Traffic shaping: sender gap odds (stimulus only) and receiver stall odds
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  // Flipping hold_toggle asks the receiver for one long hold-off
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;

  // Register values last loaded, used to aim readings at the tracking band
  wfps_cfg_t cur_cfg = '{RST_FOLLOW_MODE, RST_TARGET_DISTANCE, RST_BAND_HALF_WIDTH,
                         RST_FRONT_THRESHOLD, RST_GAIN_P, RST_GAIN_I, RST_GAIN_D};

  wall_follow_pid_steer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  wfps_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stall per cycle, or a long hold-off when asked. The long
  // hold lets the block's queue fill so in_stall has to rise.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_toggle) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // One input transfer: optional random gap, then hold the reading until taken.
  task automatic send_item(input wfps_in_t item);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_reading(input int front, input int left, input int right);
    send_item({16'(front), 16'(left), 16'(right)});
  endtask

  // Stop offering and wait until every expected result has been taken. The
  // checker's count is registered, hence the first wait. Every reading gives
  // one result, so a short tail covers the pipeline.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all registers, plus the unused index which must be ignored. Junk in
  // the upper bits of the mode write checks the masking.
  task automatic load_settings(input wfps_cfg_t s);
    logic [15:0] vals [8];
    vals[CFG_FOLLOW_MODE]     = {14'($urandom), s.follow_mode};
    vals[CFG_TARGET_DISTANCE] = s.target_distance;
    vals[CFG_BAND_HALF_WIDTH] = s.band_half_width;
    vals[CFG_FRONT_THRESHOLD] = s.front_threshold;
    vals[CFG_GAIN_P]          = s.gain_p;
    vals[CFG_GAIN_I]          = s.gain_i;
    vals[CFG_GAIN_D]          = s.gain_d;
    vals[CFG_UNUSED]          = 16'($urandom);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    cur_cfg = s;
  endtask

  // Half the time a gentle gain so the command is not always clamped.
  function automatic logic signed [15:0] pick_gain();
    if ($urandom_range(0, 1) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 2047)) - 1024);
  endfunction

  // Phases alternate right and left wall; now and then a stop or unused mode.
  function automatic wfps_cfg_t pick_settings(input int ph);
    wfps_cfg_t s;
    if ($urandom_range(0, 9) == 0) s.follow_mode = 2'($urandom_range(0, 3));
    else s.follow_mode = ph[0] ? MODE_LEFT : MODE_RIGHT;
    s.target_distance = 16'($urandom);
    if ($urandom_range(0, 3) == 0) s.band_half_width = 16'($urandom);
    else s.band_half_width = 16'($urandom_range(1, 3000));
    s.front_threshold = 16'($urandom_range(0, 43690));
    s.gain_p = pick_gain();
    s.gain_i = pick_gain();
    s.gain_d = pick_gain();
    return s;
  endfunction

  // Mostly well-formed readings: followed side inside the band (often at its
  // edges) and the front reading aimed at each speed zone. The rest is noise.
  function automatic wfps_in_t make_reading(input wfps_cfg_t s);
    wfps_in_t rd;
    int       lo, hi, side, thr;
    rd.front_distance = 16'($urandom);
    rd.left_distance  = 16'($urandom);
    rd.right_distance = 16'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      lo  = int'(s.target_distance) - int'(s.band_half_width) + 1;
      hi  = int'(s.target_distance) + int'(s.band_half_width) - 1;
      if (lo < 0) lo = 0;
      if (hi > 65535) hi = 65535;
      if (lo <= hi) begin
        case ($urandom_range(0, 7))
          0:       side = lo;
          1:       side = hi;
          default: side = int'($urandom_range(hi, lo));
        endcase
        if (s.follow_mode == MODE_LEFT) rd.left_distance = 16'(side);
        else rd.right_distance = 16'(side);
      end
      thr = s.front_threshold;
      case ($urandom_range(0, 3))
        0: rd.front_distance = '0;
        1: if (thr > 0) rd.front_distance = 16'($urandom_range(0, thr - 1));
        2: if (thr > 1) rd.front_distance = 16'($urandom_range(thr, (3 * thr - 1) / 2));
        default: ;
      endcase
      // equal side readings pick the negative evasive turn
      if ($urandom_range(0, 7) == 0) begin
        if (s.follow_mode == MODE_LEFT) rd.right_distance = rd.left_distance;
        else rd.left_distance = rd.right_distance;
      end
    end
    return rd;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: right wall, target 2.0, band 2.0, threshold 3.0
    send_reading(0, 100, 512);       // zero error
    send_reading(0, 100, 700);       // negative error
    send_reading(0, 100, 1);         // just inside lower bound
    send_reading(0, 100, 0);         // lower bound itself is outside
    send_reading(0, 100, 1024);      // upper bound itself is outside
    send_reading(0, 100, 1023);      // just inside upper bound
    send_reading(1152, 100, 600);    // exactly 1.5 x threshold: not slowed
    send_reading(1151, 100, 600);    // slowed
    send_reading(768, 100, 600);     // at threshold: slowed, not evasive
    send_reading(767, 100, 600);     // evasive, left closer: positive turn
    send_reading(1, 600, 600);       // evasive, equal sides: negative turn
    send_reading(65535, 65535, 65535);
    wait_drained();

    // Widest band on the left wall, top P and I gains: clamp and positive saturation
    load_settings('{MODE_LEFT, 16'hFFFF, 16'hFFFF, 16'd43690,
                    16'sh7FFF, 16'sh7FFF, 16'sh8000});
    send_reading(65535, 1, 0);       // front at 1.5 x max threshold: not slowed
    send_reading(65535, 1, 0);
    send_reading(65534, 1, 0);       // slowed
    send_reading(43689, 1, 0);       // evasive, negative turn
    send_reading(0, 65535, 0);       // zero error
    send_reading(0, 0, 0);           // band bottom at zero is outside
    wait_drained();

    // Right wall, most negative P and I gains: negative saturation, zero threshold
    load_settings('{MODE_RIGHT, 16'hFFFF, 16'hFFFF, 16'd0,
                    16'sh8000, 16'sh8000, 16'sh7FFF});
    send_reading(0, 0, 1);
    send_reading(0, 0, 1);
    send_reading(5, 0, 65535);
    wait_drained();

    load_settings('{MODE_STOP, 16'd512, 16'd512, 16'd768, 16'sd77, 16'sd10, 16'sd768});
    send_reading(100, 0, 512);
    wait_drained();
    load_settings('{MODE_UNUSED, 16'd512, 16'd512, 16'd768, 16'sd77, 16'sd10, 16'sd768});
    send_reading(100, 0, 512);
    wait_drained();
    // empty band: nothing can be tracked
    load_settings('{MODE_RIGHT, 16'd0, 16'd0, 16'd768, 16'sd77, 16'sd10, 16'sd768});
    send_reading(0, 0, 0);
    wait_drained();

    // Random phases, each under new settings and one of four traffic patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      load_settings(pick_settings(ph));
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 54; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 54; end
        default: begin send_idle_pct = 9; stall_pct <= 9; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // back-pressure: receiver holds off while readings keep coming
        if (ph == 4 && n == 20) hold_toggle <= ~hold_toggle;
        // sender pause until the block has delivered everything
        if (ph == 1 && n == PHASE_ITEMS / 2) wait_drained();
        send_item(make_reading(cur_cfg));
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### wall_follow_pid_steer_top.f
sv/wfps_pkg.sv
sv/wfps_front.sv
sv/wfps_queue.sv
sv/wfps_back.sv
sv/wall_follow_pid_steer_top.sv
sv/wfps_checker.sv
sim/wfps_checker.sv
sim/wall_follow_pid_steer_top_tb.sv
